/* rtl/gf2_row_reduce_pivot_table_unit_defines.svh */
// Assertion macros for the GF(2) row reduction unit.
// Included by the top level; needs clk and rst_n in scope.
`ifndef GF2_ROW_REDUCE_PIVOT_TABLE_UNIT_DEFINES_SVH
`define GF2_ROW_REDUCE_PIVOT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GF2RR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GF2RR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gf2rr_pkg.sv */
// Shared types, constants and functions of the GF(2) row reduction unit.
// No dependencies.
package gf2rr_pkg;

  localparam int COL_COUNT   = 256;
  localparam int ROW_WORDS   = 4;
  localparam int MAX_COLS    = ROW_WORDS * 64;
  localparam int EFF_COLS    = (COL_COUNT < MAX_COLS) ? COL_COUNT : MAX_COLS;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_REDUCE = 1'b1
  } op_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  word_index;
    logic [63:0] row_word;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  out_index;
    logic [63:0] out_word;
    logic        out_last;
    logic        promoted;
    logic        is_zero;
    logic [7:0]  leading_term;
  } out_word_t;

  // A closed row as handed from the front to the back.
  typedef struct packed {
    logic                         op;
    logic [1:0]                   last_idx;
    logic [ROW_WORDS-1:0][63:0]   words;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_RD,
    ST_RX,
    ST_WR,
    ST_EMIT
  } back_state_t;

  // Status of the back end, watched by the top level checks.
  typedef struct packed {
    back_state_t state;
    logic [1:0]  cnt;
    logic [1:0]  last_idx;
    logic        pop;
  } back_status_t;

  typedef struct packed {
    logic       found;
    logic [7:0] col;
  } lead_t;

  // Mask of columns kept in word w.
  function automatic logic [63:0] col_mask(input int w);
    int n;
    n = EFF_COLS - w * 64;
    if (n <= 0) return '0;
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Leading set column of a row.
  function automatic lead_t lead_find(input logic [MAX_COLS-1:0] row);
    lead_t r;
    r = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (row[i]) begin
        r.found = 1'b1;
        r.col   = 8'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/gf2rr_front.sv */
// Front end: gathers input words into the row buffer and closes rows.
// Depends on gf2rr_pkg.
module gf2rr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gf2rr_pkg::in_word_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output gf2rr_pkg::row_t    q_row
);
  import gf2rr_pkg::*;

  logic [ROW_WORDS-1:0][63:0] buf_r, buf_nxt;
  logic                       acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign q_push   = acc && in_data.last_word;

  // Closed row: current word merged, words above the last dropped, width masked.
  always_comb begin
    q_row.op       = in_data.op;
    q_row.last_idx = in_data.word_index;
    for (int w = 0; w < ROW_WORDS; w++) begin
      if (w == int'(in_data.word_index)) begin
        q_row.words[w] = in_data.row_word & col_mask(w);
      end else if (w < int'(in_data.word_index)) begin
        q_row.words[w] = buf_r[w] & col_mask(w);
      end else begin
        q_row.words[w] = '0;
      end
    end
  end

  // Buffer update: store a word, or clear once the row closes.
  always_comb begin
    buf_nxt = buf_r;
    if (acc) begin
      if (in_data.last_word) begin
        buf_nxt = '0;
      end else begin
        buf_nxt[in_data.word_index] = in_data.row_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
    end else begin
      buf_r <= buf_nxt;
    end
  end

endmodule

/* rtl/gf2rr_queue.sv */
// Two-entry queue of closed rows between front and back.
// Depends on gf2rr_pkg.
module gf2rr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gf2rr_pkg::row_t push_row,
  input  logic            pop,
  output gf2rr_pkg::row_t pop_row,
  output logic            full,
  output logic            empty
);
  import gf2rr_pkg::*;

  row_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_row = mem_r[rp_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/gf2rr_back.sv */
// Back end: reduces or loads a closed row against the pivot table and emits words.
// Depends on gf2rr_pkg.
module gf2rr_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  gf2rr_pkg::row_t          q_row,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output gf2rr_pkg::out_word_t     out_data,
  output gf2rr_pkg::back_status_t  status
);
  import gf2rr_pkg::*;

  back_state_t                st_r, st_nxt;
  logic [ROW_WORDS-1:0][63:0] row_r, row_nxt;
  logic                       op_r, op_nxt;
  logic [1:0]                 last_r, last_nxt;
  logic [7:0]                 k_r, k_nxt;
  logic                       zero_r, zero_nxt;
  logic                       prom_r, prom_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic [MAX_COLS-1:0]        valid_r, valid_nxt;
  logic                       ov_r, ov_nxt;
  out_word_t                  od_r, od_nxt;
  logic                       od_load;
  lead_t                      lead;

  // Pivot rows: slot k, word w at address {k, w}.
  logic [63:0] piv_mem [1024];
  logic [63:0] rd_data_r;
  logic        wr_en;
  logic [9:0]  mem_addr;

  assign lead     = lead_find(row_r);
  assign mem_addr = {k_r, cnt_r};
  assign wr_en    = (st_r == ST_WR);

  always_ff @(posedge clk) begin
    if (wr_en) piv_mem[mem_addr] <= row_r[cnt_r];
    rd_data_r <= piv_mem[mem_addr];
  end

  // Sequencer: leading search, pivot read and XOR, pivot write, emission.
  always_comb begin
    st_nxt    = st_r;
    row_nxt   = row_r;
    op_nxt    = op_r;
    last_nxt  = last_r;
    k_nxt     = k_r;
    zero_nxt  = zero_r;
    prom_nxt  = prom_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    q_pop     = 1'b0;
    ov_nxt    = ov_r && out_stall;
    od_load   = 1'b0;
    od_nxt    = od_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          row_nxt  = q_row.words;
          op_nxt   = q_row.op;
          last_nxt = q_row.last_idx;
          prom_nxt = 1'b0;
          cnt_nxt  = '0;
          st_nxt   = ST_LEAD;
        end
      end
      ST_LEAD: begin
        k_nxt    = lead.found ? lead.col : 8'd0;
        zero_nxt = !lead.found;
        cnt_nxt  = '0;
        if (!lead.found) begin
          st_nxt = (op_r == OP_REDUCE) ? ST_EMIT : ST_IDLE;
        end else if (op_r == OP_LOAD) begin
          st_nxt = ST_WR;
        end else if (!valid_r[lead.col]) begin
          prom_nxt = 1'b1;
          st_nxt   = ST_WR;
        end else begin
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        st_nxt = ST_RX;
      end
      ST_RX: begin
        row_nxt[cnt_r] = row_r[cnt_r] ^ rd_data_r;
        cnt_nxt        = cnt_r + 2'd1;
        st_nxt         = (cnt_r == 2'(ROW_WORDS - 1)) ? ST_LEAD : ST_RD;
      end
      ST_WR: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'(ROW_WORDS - 1)) begin
          valid_nxt[k_r] = 1'b1;
          st_nxt         = (op_r == OP_REDUCE) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          od_load = 1'b1;
          ov_nxt  = 1'b1;
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == last_r) begin
            cnt_nxt = '0;
            st_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (od_load) begin
      od_nxt.out_index    = cnt_r;
      od_nxt.out_word     = row_r[cnt_r];
      od_nxt.out_last     = (cnt_r == last_r);
      od_nxt.promoted     = prom_r;
      od_nxt.is_zero      = zero_r;
      od_nxt.leading_term = zero_r ? 8'd0 : k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      valid_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Row payload registers.
  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    op_r   <= op_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    zero_r <= zero_nxt;
    prom_r <= prom_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid       = ov_r;
  assign out_data        = od_r;
  assign status.state    = st_r;
  assign status.cnt      = cnt_r;
  assign status.last_idx = last_r;
  assign status.pop      = q_pop;

endmodule

/* rtl/gf2_row_reduce_pivot_table_unit.sv */
// Top level of the GF(2) row reduction unit: front, row queue, back.
// Depends on gf2rr_pkg and gf2_row_reduce_pivot_table_unit_defines.svh.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_data (op, word_index, row_word, last_word)
//   out     | output    | out_valid/out_stall | out_data (index, word, last, flags, lead)
//
// Words that do not close a row are taken one per cycle while the row queue is not full.
// A closed row takes a leading search, then for each pivot XOR 4 reads of the pivot
// port and a new leading search, plus 4 writes for a pivot write and the emitted words.
// The single-port pivot memory, one 64-bit word per cycle, bounds this sequence.
// Reset is synchronous, active low, and clears all pivot valid bits at once.
// Input stalls only while the two-entry row queue is full; output stalls hold the word.
`include "gf2_row_reduce_pivot_table_unit_defines.svh"
module gf2_row_reduce_pivot_table_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gf2rr_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gf2rr_pkg::out_word_t out_data
);
  import gf2rr_pkg::*;

  logic         q_push, q_pop, q_full, q_empty;
  row_t         push_row, pop_row;
  back_status_t status;

  // Front end.
  gf2rr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_row    (push_row)
  );

  // Row queue.
  gf2rr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_row (push_row),
    .pop      (q_pop),
    .pop_row  (pop_row),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end.
  gf2rr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_row     (pop_row),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  // Checks on the internal flow.
  `GF2RR_ASSERT_NOW(a_pop_nonempty, status.pop, !q_empty, "pop from empty row queue")
  `GF2RR_ASSERT_NOW(a_emit_range, status.state == ST_EMIT, status.cnt <= status.last_idx, "emit count past last word")
  `GF2RR_ASSERT_NOW(a_zero_word, out_valid && out_data.is_zero, out_data.out_word == 64'd0 && out_data.leading_term == 8'd0, "zero row with set bits")

endmodule
